/* rtl/tvc_pkg.sv */
`timescale 1ns / 1ps
// Package for the track-to-vertex chi2 block: payload structs, fixed-point
// widths, output scaling and register indexes. No dependencies.
package tvc_pkg;

  // Output scale is 2^-OUT_FRAC_BITS (legal range 8..40).
  localparam int OUT_FRAC_BITS = 24;

  localparam int CW      = 84;       // transported variance width
  localparam int NW      = 128;      // divider numerator width
  localparam int DW      = 96;       // divider denominator width
  localparam int QW      = 63;       // quotient bits kept before saturation
  localparam int DIV_LAT = QW + 1;   // divider register stages
  localparam int NTERM   = 12;       // quotient terms per item

  // Numerator shifts of each quotient kind; a negative shift moves to the denominator.
  localparam int SH_INV = 40 + OUT_FRAC_BITS;
  localparam int SH_T   = 10 + OUT_FRAC_BITS;
  localparam int SH_TT  = OUT_FRAC_BITS - 20;
  localparam int SH_R   = 24 + OUT_FRAC_BITS;
  localparam int SH_TR  = OUT_FRAC_BITS - 6;
  localparam int SH_RR  = OUT_FRAC_BITS + 8;

  localparam int NSH_INV = (SH_INV > 0) ? SH_INV : 0;
  localparam int DSH_INV = (SH_INV < 0) ? -SH_INV : 0;
  localparam int NSH_T   = (SH_T > 0) ? SH_T : 0;
  localparam int DSH_T   = (SH_T < 0) ? -SH_T : 0;
  localparam int NSH_TT  = (SH_TT > 0) ? SH_TT : 0;
  localparam int DSH_TT  = (SH_TT < 0) ? -SH_TT : 0;
  localparam int NSH_R   = (SH_R > 0) ? SH_R : 0;
  localparam int DSH_R   = (SH_R < 0) ? -SH_R : 0;
  localparam int NSH_TR  = (SH_TR > 0) ? SH_TR : 0;
  localparam int DSH_TR  = (SH_TR < 0) ? -SH_TR : 0;
  localparam int NSH_RR  = (SH_RR > 0) ? SH_RR : 0;
  localparam int DSH_RR  = (SH_RR < 0) ? -SH_RR : 0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VX = 2'd0;
  localparam logic [1:0] CFG_VY = 2'd1;
  localparam logic [1:0] CFG_VZ = 2'd2;

  typedef struct packed {
    logic signed [31:0] track_x;
    logic signed [31:0] track_y;
    logic signed [31:0] track_z;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic [47:0]        var_x;
    logic [47:0]        var_y;
    logic signed [47:0] cov_x_slope;
    logic [47:0]        var_slope_x;
    logic signed [47:0] cov_y_slope;
    logic [47:0]        var_slope_y;
  } trk_t;

  typedef struct packed {
    logic signed [63:0] hess_xx;
    logic signed [63:0] hess_yy;
    logic signed [63:0] hess_zx;
    logic signed [63:0] hess_zy;
    logic signed [63:0] hess_zz;
    logic signed [63:0] grad_x;
    logic signed [63:0] grad_y;
    logic signed [63:0] grad_z;
    logic [62:0]        chi_square;
    logic               bad_variance;
  } res_t;

endpackage

/* rtl/tvc_trk_if.sv */
`timescale 1ns / 1ps
// Track input channel: valid/ready handshake with one track state per transfer.
// Depends on tvc_pkg.
interface tvc_trk_if import tvc_pkg::*; ();
  logic valid;
  logic ready;
  trk_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tvc_res_if.sv */
`timescale 1ns / 1ps
// Result output channel: valid/ready handshake with one result per transfer.
// Depends on tvc_pkg.
interface tvc_res_if import tvc_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/tvc_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, saturating at 2^63-1.
// Depends on tvc_pkg for widths.
module tvc_div import tvc_pkg::*; (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int EW = DW + QW;

  logic [NW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] quo_q [QW+1];
  logic          sat_q [QW+1];

  // Quotient of 2^63 or more saturates.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
      sat_q[0] <= EW'(num_i) >= (EW'(den_i) << QW);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    localparam logic [QW-1:0] BIT = QW'(1) << B;
    logic [EW-1:0] sub;
    logic          take;

    assign sub  = EW'(den_q[k-1]) << B;
    assign take = EW'(rem_q[k-1]) >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? NW'(EW'(rem_q[k-1]) - sub) : rem_q[k-1];
        den_q[k] <= den_q[k-1];
        sat_q[k] <= sat_q[k-1];
        quo_q[k] <= take ? (quo_q[k-1] | BIT) : quo_q[k-1];
      end
    end
  end

  assign quo_o = sat_q[QW] ? '1 : quo_q[QW];

endmodule

/* rtl/track_vertex_chi2_terms.sv */
`timescale 1ns / 1ps
// Track-to-vertex chi2 with half gradient and half Hessian, fully pipelined.
// Path from input transfer to result valid: front stages, divider stages, output register.
// Throughput: one track per cycle; a result stalled at the output freezes
//   the whole pipe (global enable), so nothing is dropped or repeated.
// Depth is set by the 64 stages of the twelve dividers: a saturation check,
//   then 63 stages of one quotient bit each.
// Reset: asynchronous, active low; clears vertex registers and valid bits.
module track_vertex_chi2_terms import tvc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  tvc_trk_if.sink     trk_i,
  tvc_res_if.source   res_o
);

  localparam int PL = 7 + DIV_LAT;
  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

  // Term slots of the divider bank.
  localparam int T_INVX = 0;
  localparam int T_INVY = 1;
  localparam int T_TX   = 2;
  localparam int T_TY   = 3;
  localparam int T_TTX  = 4;
  localparam int T_TTY  = 5;
  localparam int T_RX   = 6;
  localparam int T_RY   = 7;
  localparam int T_TRX  = 8;
  localparam int T_TRY  = 9;
  localparam int T_RRX  = 10;
  localparam int T_RRY  = 11;

  // Sign and bad flags that travel beside the dividers.
  typedef struct packed {
    logic bad;
    logic n_zx;
    logic n_zy;
    logic n_gx;
    logic n_gy;
    logic n_tx;
    logic n_ty;
  } flg_t;

  // ---------------------------------------------------------------- config
  logic signed [31:0] vx_q, vy_q, vz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0;
      vy_q <= '0;
      vz_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VX:  vx_q <= cfg_data_i;
        CFG_VY:  vy_q <= cfg_data_i;
        CFG_VZ:  vz_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ handshake
  // Advance every stage unless a finished result is waiting at the output.
  logic          adv;
  logic [PL-1:0] vld_q;
  logic          out_vld_q;
  res_t          out_q;

  assign adv         = !out_vld_q || res_o.ready;
  assign trk_i.ready = adv;
  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[PL-2:0], trk_i.valid};
      out_vld_q <= vld_q[PL-1];
    end
  end

  // Index 0 is the x lane, index 1 the y lane.
  logic signed [31:0] vtx [2];
  assign vtx[0] = vx_q;
  assign vtx[1] = vy_q;

  // ------------------------------------------------------------ stage 1
  // Capture the track and form dz = vertex_z - track_z.
  logic signed [32:0] s1_dz_q;
  logic signed [31:0] s1_pos_q [2];
  logic signed [31:0] s1_slp_q [2];
  logic [47:0]        s1_var_q [2];
  logic signed [47:0] s1_cov_q [2];
  logic [47:0]        s1_vs_q  [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dz_q     <= 33'(vz_q) - 33'(trk_i.data.track_z);
      s1_pos_q[0] <= trk_i.data.track_x;
      s1_pos_q[1] <= trk_i.data.track_y;
      s1_slp_q[0] <= trk_i.data.slope_x;
      s1_slp_q[1] <= trk_i.data.slope_y;
      s1_var_q[0] <= trk_i.data.var_x;
      s1_var_q[1] <= trk_i.data.var_y;
      s1_cov_q[0] <= trk_i.data.cov_x_slope;
      s1_cov_q[1] <= trk_i.data.cov_y_slope;
      s1_vs_q[0]  <= trk_i.data.var_slope_x;
      s1_vs_q[1]  <= trk_i.data.var_slope_y;
    end
  end

  // ------------------------------------------------------------ stage 2
  // Take magnitudes and the first partial products of |dz|.
  logic [32:0] adz;
  logic [31:0] mslp [2];
  logic [47:0] mcov [2];

  always_comb begin
    adz = s1_dz_q[32] ? 33'(-s1_dz_q) : 33'(s1_dz_q);
    for (int i = 0; i < 2; i++) begin
      mslp[i] = s1_slp_q[i][31] ? 32'(-s1_slp_q[i]) : 32'(s1_slp_q[i]);
      mcov[i] = s1_cov_q[i][47] ? 48'(-s1_cov_q[i]) : 48'(s1_cov_q[i]);
    end
  end

  logic [49:0]        s2_sqh_q;
  logic [48:0]        s2_sql_q;
  logic [48:0]        s2_pth_q  [2];
  logic [47:0]        s2_ptl_q  [2];
  logic [64:0]        s2_pch_q  [2];
  logic [63:0]        s2_pcl_q  [2];
  logic               s2_dzneg_q;
  logic               s2_sneg_q [2];
  logic               s2_cneg_q [2];
  logic [31:0]        s2_mslp_q [2];
  logic signed [31:0] s2_pos_q  [2];
  logic [47:0]        s2_var_q  [2];
  logic [47:0]        s2_vs_q   [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sqh_q   <= 50'(adz[32:16]) * 50'(adz);
      s2_sql_q   <= 49'(adz[15:0]) * 49'(adz);
      s2_dzneg_q <= s1_dz_q[32];
      for (int i = 0; i < 2; i++) begin
        s2_pth_q[i]  <= 49'(adz[32:16]) * 49'(mslp[i]);
        s2_ptl_q[i]  <= 48'(adz[15:0]) * 48'(mslp[i]);
        s2_pch_q[i]  <= 65'(adz[32:16]) * 65'(mcov[i]);
        s2_pcl_q[i]  <= 64'(adz[15:0]) * 64'(mcov[i]);
        s2_sneg_q[i] <= s1_slp_q[i][31];
        s2_cneg_q[i] <= s1_cov_q[i][47];
        s2_mslp_q[i] <= mslp[i];
        s2_pos_q[i]  <= s1_pos_q[i];
        s2_var_q[i]  <= s1_var_q[i];
        s2_vs_q[i]   <= s1_vs_q[i];
      end
    end
  end

  // ------------------------------------------------------------ stage 3
  // Sum partials; move the track to vertex z (round half up) and form the residual.
  logic [65:0]        sq;
  logic [64:0]        mdt  [2];
  logic signed [65:0] pdt  [2];
  logic signed [65:0] pdr  [2];
  logic signed [35:0] fs   [2];
  logic signed [36:0] res  [2];
  logic [80:0]        mtc  [2];

  always_comb begin
    sq = {s2_sqh_q, 16'd0} + 66'(s2_sql_q);
    for (int i = 0; i < 2; i++) begin
      mdt[i] = {s2_pth_q[i], 16'd0} + 65'(s2_ptl_q[i]);
      pdt[i] = (s2_dzneg_q ^ s2_sneg_q[i]) ? -$signed({1'b0, mdt[i]})
                                           : $signed({1'b0, mdt[i]});
      pdr[i] = pdt[i] + 66'sd536870912;
      fs[i]  = 36'(pdr[i] >>> 30);
      res[i] = 37'(vtx[i]) - 37'(s2_pos_q[i]) - 37'(fs[i]);
      mtc[i] = {s2_pch_q[i], 16'd0} + 81'(s2_pcl_q[i]);
    end
  end

  logic [63:0]        s3_adz2_q;
  logic signed [36:0] s3_res_q  [2];
  logic [80:0]        s3_tm_q   [2];
  logic               s3_tneg_q [2];
  logic [31:0]        s3_mslp_q [2];
  logic               s3_sneg_q [2];
  logic [47:0]        s3_var_q  [2];
  logic [47:0]        s3_vs_q   [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_adz2_q <= sq[63:0];  // wraps at 64 bits
      for (int i = 0; i < 2; i++) begin
        s3_res_q[i]  <= res[i];
        s3_tm_q[i]   <= mtc[i];
        s3_tneg_q[i] <= s2_dzneg_q ^ s2_cneg_q[i];
        s3_mslp_q[i] <= s2_mslp_q[i];
        s3_sneg_q[i] <= s2_sneg_q[i];
        s3_var_q[i]  <= s2_var_q[i];
        s3_vs_q[i]   <= s2_vs_q[i];
      end
    end
  end

  // ------------------------------------------------------------ stage 4
  // dz^2 * var_slope in 16-bit slices; signed cross term; residual magnitude.
  logic [127:0] tsh [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tsh[i] = 128'(s3_tm_q[i]) << 17;
    end
  end

  logic [63:0]  s4_ps_q   [2][4];
  logic [127:0] s4_tw_q   [2];
  logic [35:0]  s4_mres_q [2];
  logic         s4_rneg_q [2];
  logic [31:0]  s4_mslp_q [2];
  logic         s4_sneg_q [2];
  logic [47:0]  s4_var_q  [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        for (int k = 0; k < 4; k++) begin
          s4_ps_q[i][k] <= 64'(s3_adz2_q[16*k +: 16]) * 64'(s3_vs_q[i]);
        end
        s4_tw_q[i]   <= s3_tneg_q[i] ? -tsh[i] : tsh[i];
        s4_mres_q[i] <= s3_res_q[i][36] ? 36'(-s3_res_q[i]) : 36'(s3_res_q[i]);
        s4_rneg_q[i] <= s3_res_q[i][36];
        s4_mslp_q[i] <= s3_mslp_q[i];
        s4_sneg_q[i] <= s3_sneg_q[i];
        s4_var_q[i]  <= s3_var_q[i];
      end
    end
  end

  // ------------------------------------------------------------ stage 5
  // Add the slices; start the numerator products.
  logic [127:0] s5_sum_q  [2];
  logic [127:0] s5_tw_q   [2];
  logic [63:0]  s5_tt_q   [2];
  logic [51:0]  s5_trh_q  [2];
  logic [47:0]  s5_trl_q  [2];
  logic [55:0]  s5_rrh_q  [2];
  logic [51:0]  s5_rrl_q  [2];
  logic [35:0]  s5_mres_q [2];
  logic         s5_rneg_q [2];
  logic [31:0]  s5_mslp_q [2];
  logic         s5_sneg_q [2];
  logic [47:0]  s5_var_q  [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        s5_sum_q[i]  <= 128'(s4_ps_q[i][0]) + (128'(s4_ps_q[i][1]) << 16)
                      + (128'(s4_ps_q[i][2]) << 32) + (128'(s4_ps_q[i][3]) << 48);
        s5_tw_q[i]   <= s4_tw_q[i];
        s5_tt_q[i]   <= 64'(s4_mslp_q[i]) * 64'(s4_mslp_q[i]);
        s5_trh_q[i]  <= 52'(s4_mres_q[i][35:16]) * 52'(s4_mslp_q[i]);
        s5_trl_q[i]  <= 48'(s4_mres_q[i][15:0]) * 48'(s4_mslp_q[i]);
        s5_rrh_q[i]  <= 56'(s4_mres_q[i][35:16]) * 56'(s4_mres_q[i]);
        s5_rrl_q[i]  <= 52'(s4_mres_q[i][15:0]) * 52'(s4_mres_q[i]);
        s5_mres_q[i] <= s4_mres_q[i];
        s5_rneg_q[i] <= s4_rneg_q[i];
        s5_mslp_q[i] <= s4_mslp_q[i];
        s5_sneg_q[i] <= s4_sneg_q[i];
        s5_var_q[i]  <= s4_var_q[i];
      end
    end
  end

  // ------------------------------------------------------------ stage 6
  // Add cross term and rounding; finish the numerator products.
  logic [127:0] s6_w_q    [2];
  logic [63:0]  s6_tt_q   [2];
  logic [67:0]  s6_tr_q   [2];
  logic [71:0]  s6_rr_q   [2];
  logic [35:0]  s6_mres_q [2];
  logic         s6_rneg_q [2];
  logic [31:0]  s6_mslp_q [2];
  logic         s6_sneg_q [2];
  logic [47:0]  s6_var_q  [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        s6_w_q[i]    <= s5_sum_q[i] + s5_tw_q[i] + (128'(1) << 31);
        s6_tt_q[i]   <= s5_tt_q[i];
        s6_tr_q[i]   <= {s5_trh_q[i], 16'd0} + 68'(s5_trl_q[i]);
        s6_rr_q[i]   <= {s5_rrh_q[i], 16'd0} + 72'(s5_rrl_q[i]);
        s6_mres_q[i] <= s5_mres_q[i];
        s6_rneg_q[i] <= s5_rneg_q[i];
        s6_mslp_q[i] <= s5_mslp_q[i];
        s6_sneg_q[i] <= s5_sneg_q[i];
        s6_var_q[i]  <= s5_var_q[i];
      end
    end
  end

  // ------------------------------------------------------------ stage 7
  // Scale down by 2^32 (floor), add the old variance, test for a bad variance.
  logic [127:0] cv  [2];
  logic         bad [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      cv[i]  = 128'($signed(s6_w_q[i]) >>> 32) + 128'(s6_var_q[i]);
      bad[i] = cv[i][127] || (cv[i] == '0);
    end
  end

  logic [CW-1:0] s7_c_q    [2];
  logic          s7_bad_q;
  logic [63:0]   s7_tt_q   [2];
  logic [67:0]   s7_tr_q   [2];
  logic [71:0]   s7_rr_q   [2];
  logic [35:0]   s7_mres_q [2];
  logic          s7_rneg_q [2];
  logic [31:0]   s7_mslp_q [2];
  logic          s7_sneg_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_bad_q <= bad[0] || bad[1];
      for (int i = 0; i < 2; i++) begin
        s7_c_q[i]    <= cv[i][CW-1:0];
        s7_tt_q[i]   <= s6_tt_q[i];
        s7_tr_q[i]   <= s6_tr_q[i];
        s7_rr_q[i]   <= s6_rr_q[i];
        s7_mres_q[i] <= s6_mres_q[i];
        s7_rneg_q[i] <= s6_rneg_q[i];
        s7_mslp_q[i] <= s6_mslp_q[i];
        s7_sneg_q[i] <= s6_sneg_q[i];
      end
    end
  end

  // ------------------------------------------------------------ divider bank
  logic [NW-1:0] num [NTERM];
  logic [DW-1:0] den [NTERM];
  logic [QW-1:0] quo [NTERM];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      num[T_INVX + i] = NW'(1) << NSH_INV;
      den[T_INVX + i] = DW'(s7_c_q[i]) << DSH_INV;
      num[T_TX + i]   = NW'(s7_mslp_q[i]) << NSH_T;
      den[T_TX + i]   = DW'(s7_c_q[i]) << DSH_T;
      num[T_TTX + i]  = NW'(s7_tt_q[i]) << NSH_TT;
      den[T_TTX + i]  = DW'(s7_c_q[i]) << DSH_TT;
      num[T_RX + i]   = NW'(s7_mres_q[i]) << NSH_R;
      den[T_RX + i]   = DW'(s7_c_q[i]) << DSH_R;
      num[T_TRX + i]  = NW'(s7_tr_q[i]) << NSH_TR;
      den[T_TRX + i]  = DW'(s7_c_q[i]) << DSH_TR;
      num[T_RRX + i]  = NW'(s7_rr_q[i]) << NSH_RR;
      den[T_RRX + i]  = DW'(s7_c_q[i]) << DSH_RR;
    end
  end

  for (genvar t = 0; t < NTERM; t++) begin : g_div
    tvc_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num[t]),
      .den_i (den[t]),
      .quo_o (quo[t])
    );
  end

  // Delay the sign and bad flags to line up with the quotients.
  flg_t flg_in;
  flg_t flg_q [DIV_LAT];

  always_comb begin
    flg_in.bad  = s7_bad_q;
    flg_in.n_zx = !s7_sneg_q[0];
    flg_in.n_zy = !s7_sneg_q[1];
    flg_in.n_gx = s7_rneg_q[0];
    flg_in.n_gy = s7_rneg_q[1];
    flg_in.n_tx = s7_sneg_q[0] == s7_rneg_q[0];
    flg_in.n_ty = s7_sneg_q[1] == s7_rneg_q[1];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flg_q[0] <= flg_in;
      for (int k = 1; k < DIV_LAT; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
    end
  end

  // ------------------------------------------------------------ output
  function automatic logic signed [63:0] apply_sign(input logic [QW-1:0] q, input logic neg);
    logic signed [63:0] v;
    v = $signed({1'b0, q});
    return neg ? -v : v;
  endfunction

  // Clamp a two-term sum to [-(2^63-1), 2^63-1].
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) return S64_MAX;
    if (s < -65'(S64_MAX)) return -S64_MAX;
    return 64'(s);
  endfunction

  flg_t               fl;
  res_t               res_d;
  logic signed [63:0] chi;

  always_comb begin
    fl                 = flg_q[DIV_LAT-1];
    res_d.hess_xx      = apply_sign(quo[T_INVX], 1'b0);
    res_d.hess_yy      = apply_sign(quo[T_INVY], 1'b0);
    res_d.hess_zx      = apply_sign(quo[T_TX], fl.n_zx);
    res_d.hess_zy      = apply_sign(quo[T_TY], fl.n_zy);
    res_d.hess_zz      = sat_add(apply_sign(quo[T_TTX], 1'b0),
                                 apply_sign(quo[T_TTY], 1'b0));
    res_d.grad_x       = apply_sign(quo[T_RX], fl.n_gx);
    res_d.grad_y       = apply_sign(quo[T_RY], fl.n_gy);
    res_d.grad_z       = sat_add(apply_sign(quo[T_TRX], fl.n_tx),
                                 apply_sign(quo[T_TRY], fl.n_ty));
    chi                = sat_add(apply_sign(quo[T_RRX], 1'b0),
                                 apply_sign(quo[T_RRY], 1'b0));
    res_d.chi_square   = chi[62:0];
    res_d.bad_variance = fl.bad;
    // A bad variance forces every term to the positive limit.
    if (fl.bad) begin
      res_d.hess_xx    = S64_MAX;
      res_d.hess_yy    = S64_MAX;
      res_d.hess_zx    = S64_MAX;
      res_d.hess_zy    = S64_MAX;
      res_d.hess_zz    = S64_MAX;
      res_d.grad_x     = S64_MAX;
      res_d.grad_y     = S64_MAX;
      res_d.grad_z     = S64_MAX;
      res_d.chi_square = '1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res_d;
    end
  end

  // ------------------------------------------------------------ checks
  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !trk_i.ready |-> (res_o.valid && !res_o.ready))
    else $error("input held off without an output stall");

  a_bad_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.bad_variance) |->
      (res_o.data.chi_square == '1 && res_o.data.hess_xx == S64_MAX))
    else $error("bad variance result not saturated");

  a_hess_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!res_o.data.hess_xx[63] && !res_o.data.hess_yy[63] &&
                     !res_o.data.hess_zz[63]))
    else $error("diagonal Hessian term negative");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> $stable(vld_q))
    else $error("pipeline moved during an output stall");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for track_vertex_chi2_terms: drives random and corner
// track states, predicts chi2/gradient/Hessian terms in wide integer math.
// Depends on tvc_pkg, tvc_trk_if, tvc_res_if and the block itself.
module tb;
  import tvc_pkg::*;

  localparam int PIPE_LAT  = 72;
  localparam int MAX_CYCLE = 400000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  tvc_trk_if trk_ch ();
  tvc_res_if res_ch ();

  track_vertex_chi2_terms u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .trk_i(trk_ch.sink), .res_o(res_ch.source)
  );

  // Shadow copy of the vertex registers.
  logic signed [31:0] vtx_x, vtx_y, vtx_z;

  trk_t track_queue[$];
  res_t expected_res[$];
  int   err_count;
  int   cycle_count;
  int   sent_count;
  bit   in_taken;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Truncated quotient magnitude, saturated at 2^63-1.
  function automatic logic [63:0] quot_sat(logic [255:0] num, logic [255:0] den);
    logic [255:0] q;
    q = num / den;
    if (q > 256'(S64_MAX)) return S64_MAX;
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] div_term(bit neg, logic [127:0] m, int sh,
                                                  logic [127:0] den);
    logic [255:0] n, d;
    logic [63:0] q;
    n = 256'(m);
    d = 256'(den);
    if (sh >= 0) n = n << sh;
    else d = d << (-sh);
    q = quot_sat(n, d);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(S64_MAX)) return S64_MAX;
    if (s < -65'(S64_MAX)) return -S64_MAX;
    return s[63:0];
  endfunction

  // Variance carried to the vertex z; nonpositive means a bad variance.
  function automatic logic signed [127:0] carried_var(logic [47:0] c00,
      logic signed [47:0] c20, logic [47:0] c22, logic signed [63:0] dz);
    logic signed [127:0] s;
    s = 128'(dz) * 128'(dz) * $signed({80'd0, c22})
        + ((128'(dz) * 128'(c20)) <<< 17) + (128'sd1 <<< 31);
    s = s >>> 32;
    return s + $signed({80'd0, c00});
  endfunction

  function automatic logic [127:0] mag128(logic signed [63:0] v);
    return v < 0 ? 128'(-128'(v)) : 128'(v);
  endfunction

  function automatic res_t chi2_terms(trk_t t);
    res_t r;
    logic signed [63:0] dz, rx, ry, tx, ty, px, py;
    logic signed [127:0] cx, cy;
    logic [127:0] mtx, mty, mrx, mry;
    logic signed [63:0] chi;
    dz = 64'(vtx_z) - 64'(t.track_z);
    tx = 64'(t.slope_x);
    ty = 64'(t.slope_y);
    px = (dz * tx + (64'sd1 <<< 29)) >>> 30;
    py = (dz * ty + (64'sd1 <<< 29)) >>> 30;
    rx = 64'(vtx_x) - (64'(t.track_x) + px);
    ry = 64'(vtx_y) - (64'(t.track_y) + py);
    cx = carried_var(t.var_x, t.cov_x_slope, t.var_slope_x, dz);
    cy = carried_var(t.var_y, t.cov_y_slope, t.var_slope_y, dz);
    mtx = mag128(tx); mty = mag128(ty); mrx = mag128(rx); mry = mag128(ry);
    if (cx <= 0 || cy <= 0) begin
      r = '{S64_MAX, S64_MAX, S64_MAX, S64_MAX, S64_MAX, S64_MAX, S64_MAX, S64_MAX,
            63'h7FFF_FFFF_FFFF_FFFF, 1'b1};
      return r;
    end
    r.hess_xx = div_term(1'b0, 128'd1, 40 + OUT_FRAC_BITS, cx);
    r.hess_yy = div_term(1'b0, 128'd1, 40 + OUT_FRAC_BITS, cy);
    r.hess_zx = div_term(tx > 0, mtx, 10 + OUT_FRAC_BITS, cx);
    r.hess_zy = div_term(ty > 0, mty, 10 + OUT_FRAC_BITS, cy);
    r.hess_zz = add_sat(div_term(1'b0, mtx * mtx, OUT_FRAC_BITS - 20, cx),
                        div_term(1'b0, mty * mty, OUT_FRAC_BITS - 20, cy));
    r.grad_x = div_term(rx < 0, mrx, 24 + OUT_FRAC_BITS, cx);
    r.grad_y = div_term(ry < 0, mry, 24 + OUT_FRAC_BITS, cy);
    r.grad_z = add_sat(div_term((tx < 0) == (rx < 0), mtx * mrx, OUT_FRAC_BITS - 6, cx),
                       div_term((ty < 0) == (ry < 0), mty * mry, OUT_FRAC_BITS - 6, cy));
    chi = add_sat(div_term(1'b0, mrx * mrx, OUT_FRAC_BITS + 8, cx),
                  div_term(1'b0, mry * mry, OUT_FRAC_BITS + 8, cy));
    r.chi_square = chi[62:0];
    r.bad_variance = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", field, got, want);
    err_count++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  // Hold valid and data until the pending transfer has been taken.
  int burst_left, gap_left;
  always @(negedge clk_i) begin
    if (rst_ni && (!trk_ch.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        trk_ch.valid <= 1'b0;
      end else if (track_queue.size() > 0) begin
        trk_ch.valid <= 1'b1;
        trk_ch.data  <= track_queue[0];
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        end else begin
          burst_left--;
        end
      end else begin
        trk_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stalls on a slowly changing duty pattern; some phases never stall.
  int stall_pct;
  always @(negedge clk_i) begin
    if (cycle_count % 500 == 0) stall_pct = $urandom_range(0, 3) * 20;
    res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Compare every result transfer with the oldest prediction; record input transfers.
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected", 64'(res_ch.data.chi_square), 64'd0);
      end else begin
        res_t w, g;
        w = expected_res.pop_front();
        g = res_ch.data;
        if (g.hess_xx !== w.hess_xx) report_mismatch("hess_xx", g.hess_xx, w.hess_xx);
        if (g.hess_yy !== w.hess_yy) report_mismatch("hess_yy", g.hess_yy, w.hess_yy);
        if (g.hess_zx !== w.hess_zx) report_mismatch("hess_zx", g.hess_zx, w.hess_zx);
        if (g.hess_zy !== w.hess_zy) report_mismatch("hess_zy", g.hess_zy, w.hess_zy);
        if (g.hess_zz !== w.hess_zz) report_mismatch("hess_zz", g.hess_zz, w.hess_zz);
        if (g.grad_x !== w.grad_x) report_mismatch("grad_x", g.grad_x, w.grad_x);
        if (g.grad_y !== w.grad_y) report_mismatch("grad_y", g.grad_y, w.grad_y);
        if (g.grad_z !== w.grad_z) report_mismatch("grad_z", g.grad_z, w.grad_z);
        if (g.chi_square !== w.chi_square)
          report_mismatch("chi_square", 64'(g.chi_square), 64'(w.chi_square));
        if (g.bad_variance !== w.bad_variance)
          report_mismatch("bad_variance", 64'(g.bad_variance), 64'(w.bad_variance));
      end
    end
    in_taken = rst_ni && trk_ch.valid && trk_ch.ready;
    if (in_taken) begin
      expected_res.push_back(chi2_terms(trk_ch.data));
      sent_count++;
      void'(track_queue.pop_front());
    end
  end

  // Timeout guard.
  always @(posedge clk_i) begin
    if (cycle_count >= MAX_CYCLE) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic trk_t rand_track(int sz);
    trk_t t;
    // Small magnitudes keep the quotients in range; sz 0 widens everything.
    t.track_x = $urandom();
    t.track_y = $urandom();
    t.track_z = (sz == 0) ? $urandom() : $signed($urandom_range(0, 8191)) - 4096;
    t.slope_x = (sz == 0) ? $urandom() : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    t.slope_y = (sz == 0) ? $urandom() : $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    t.var_x = 48'({$urandom(), $urandom()});
    t.var_y = 48'({$urandom(), $urandom()});
    t.cov_x_slope = 48'({$urandom(), $urandom()});
    t.cov_y_slope = 48'({$urandom(), $urandom()});
    t.var_slope_x = 48'({$urandom(), $urandom()});
    t.var_slope_y = 48'({$urandom(), $urandom()});
    if (sz != 0) begin
      t.cov_x_slope = $signed(t.cov_x_slope) >>> $urandom_range(0, 40);
      t.cov_y_slope = $signed(t.cov_y_slope) >>> $urandom_range(0, 40);
      t.var_x = t.var_x >> $urandom_range(0, 47);
      t.var_y = t.var_y >> $urandom_range(0, 47);
    end
    return t;
  endfunction

  // Hold until every prediction has been checked, then drain the pipe.
  task automatic wait_idle();
    while (track_queue.size() > 0 || expected_res.size() > 0 || trk_ch.valid)
      @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_VX) vtx_x = val;
    else if (idx == CFG_VY) vtx_y = val;
    else if (idx == CFG_VZ) vtx_z = val;
  endtask

  initial begin
    trk_t t;
    logic [31:0] vtx_set[5][3];
    err_count = 0; cycle_count = 0; sent_count = 0; in_taken = 1'b0;
    burst_left = 0; gap_left = 0; stall_pct = 0;
    vtx_x = 0; vtx_y = 0; vtx_z = 0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_VX; cfg_data_i = '0;
    trk_ch.valid = 1'b0; trk_ch.data = '0; res_ch.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero vertex, exact zero variance, negative covariance, extremes.
    track_queue.push_back('0);
    t = '0; t.var_x = 48'd1; t.var_y = 48'd1;
    track_queue.push_back(t);
    t.var_y = 48'd0;
    track_queue.push_back(t);
    t = '0; t.var_x = '1; t.var_y = '1; t.var_slope_x = '1; t.var_slope_y = '1;
    t.track_z = 32'h8000_0000; t.slope_x = 32'h7FFF_FFFF; t.slope_y = 32'h8000_0000;
    t.track_x = 32'h7FFF_FFFF; t.track_y = 32'h8000_0000;
    track_queue.push_back(t);
    t.cov_x_slope = 48'h8000_0000_0000; t.cov_y_slope = 48'h7FFF_FFFF_FFFF;
    track_queue.push_back(t);
    t = '0; t.var_x = 48'd1; t.var_y = 48'd5; t.track_z = 32'd1000;
    t.cov_x_slope = 48'h8000_0000_0000;
    track_queue.push_back(t);
    t = '0; t.var_x = 48'd1; t.var_y = 48'd1; t.track_x = 32'h8000_0000;
    t.slope_x = 32'h8000_0000; t.slope_y = 32'h7FFF_FFFF;
    track_queue.push_back(t);
    for (int i = 0; i < 8; i++) track_queue.push_back(rand_track(i % 2));

    vtx_set = '{'{32'd0, 32'd0, 32'd0},
                '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF},
                '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000},
                '{32'd0, 32'd0, 32'd0}, '{32'd0, 32'd0, 32'd0}};
    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      if (ph >= 3) vtx_set[ph] = '{$urandom(), $urandom(), $signed($urandom_range(0, 8191)) - 4096};
      write_reg(CFG_VX, vtx_set[ph][0]);
      write_reg(CFG_VY, vtx_set[ph][1]);
      write_reg(CFG_VZ, vtx_set[ph][2]);
      // Index three does not exist; the write must leave the registers alone.
      write_reg(2'd3, $urandom());
      for (int i = 0; i < 190; i++)
        track_queue.push_back(rand_track($urandom_range(0, 9) != 0));
    end

    wait_idle();
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
